/* rtl/shift_request_latch_release_debounce_unit_macros.svh */
// assertion macros for the shift request latch and release debounce unit
`ifndef SHIFT_REQUEST_LATCH_RELEASE_DEBOUNCE_UNIT_MACROS_SVH
`define SHIFT_REQUEST_LATCH_RELEASE_DEBOUNCE_UNIT_MACROS_SVH

`ifndef NO_ASSERTIONS

// antecedent implies consequent in the same cycle
`define SRLRD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define SRLRD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define SRLRD_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define SRLRD_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

/* rtl/srlrd_pkg.sv */
// shared types and constants of the shift request latch and release debounce unit
`default_nettype none

package srlrd_pkg;

    localparam int unsigned COUNT_BITS_DEF = 16;
    localparam int unsigned DEBOUNCE_W     = 16;
    localparam int unsigned APB_DATA_W     = 32;
    localparam int unsigned APB_ADDR_W     = 2;

    localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RESET = 16'd20;
    localparam logic [APB_ADDR_W-1:0] ADDR_RELEASE_TICKS = 2'd0;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_CONSUME = 2'd1;
    localparam logic [1:0] OP_REARM   = 2'd2;

    localparam logic [1:0] REQ_NONE    = 2'd0;
    localparam logic [1:0] REQ_UP      = 2'd1;
    localparam logic [1:0] REQ_DOWN    = 2'd2;
    localparam logic [1:0] REQ_NEUTRAL = 2'd3;

    typedef struct packed {
        logic [1:0] op;
        logic       up_level;
        logic       down_level;
        logic       neutral_level;
    } t_in_item;

    typedef struct packed {
        logic [1:0] request_code;
        logic       wake;
        logic       armed_now;
        logic       awaiting_release;
    } t_out_item;

endpackage

`default_nettype wire

/* rtl/srlrd_cfg.sv */
// apb register file holding the release debounce tick count
`default_nettype none

module srlrd_cfg
    import srlrd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready,
    output logic      [DEBOUNCE_W-1:0] o_release_ticks
);

    logic [DEBOUNCE_W-1:0] r_ticks;
    logic [DEBOUNCE_W-1:0] n_ticks;
    logic                  wr_hit;

    assign pready = 1'b1;
    assign wr_hit = psel && penable && pwrite && (paddr == ADDR_RELEASE_TICKS);

    always_comb begin
        n_ticks = r_ticks;
        if (wr_hit) begin
            n_ticks = pwdata[DEBOUNCE_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ticks <= DEBOUNCE_RESET;
        end else begin
            r_ticks <= n_ticks;
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr == ADDR_RELEASE_TICKS) begin
            prdata = APB_DATA_W'(r_ticks);
        end
    end

    assign o_release_ticks = r_ticks;

endmodule

`default_nettype wire

/* rtl/srlrd_core.sv */
// latch, arm and release debounce state, updated from the state registers on each accepted item
`default_nettype none

module srlrd_core
    import srlrd_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_accept,
    input  wire t_in_item              i_item,
    input  wire logic [DEBOUNCE_W-1:0] i_release_ticks,
    output t_out_item                  o_result
);

    localparam int unsigned CMP_W = (COUNT_BITS > DEBOUNCE_W) ? COUNT_BITS : DEBOUNCE_W;

    logic                  r_armed;
    logic                  n_armed;
    logic                  r_waiting;
    logic                  n_waiting;
    logic [1:0]            r_pending;
    logic [1:0]            n_pending;
    logic [2:0]            r_prev;
    logic [2:0]            n_prev;
    logic                  r_seen;
    logic                  n_seen;
    logic [COUNT_BITS-1:0] r_count;
    logic [COUNT_BITS-1:0] n_count;

    logic [2:0]            levels;
    logic [2:0]            rising;
    logic [COUNT_BITS-1:0] count_step;
    logic [CMP_W-1:0]      need;
    logic [1:0]            code;
    logic                  wake;

    assign levels = {i_item.neutral_level, i_item.down_level, i_item.up_level};
    assign rising = levels & ~r_prev;
    assign need   = (i_release_ticks == '0) ? CMP_W'(1) : CMP_W'(i_release_ticks);

    always_comb begin
        n_armed    = r_armed;
        n_waiting  = r_waiting;
        n_pending  = r_pending;
        n_prev     = r_prev;
        n_seen     = r_seen;
        n_count    = r_count;
        count_step = r_count;
        code       = REQ_NONE;
        wake       = 1'b0;
        case (i_item.op)
            OP_TICK: begin
                n_prev = levels;
                if (r_armed && (r_pending == REQ_NONE) && (rising != 3'b000)) begin
                    if (rising[0]) begin
                        n_pending = REQ_UP;
                    end else if (rising[1]) begin
                        n_pending = REQ_DOWN;
                    end else begin
                        n_pending = REQ_NEUTRAL;
                    end
                    n_armed = 1'b0;
                    wake    = 1'b1;
                end
                if (r_waiting) begin
                    if (levels == 3'b000) begin
                        if (!r_seen) begin
                            count_step = '0;
                        end else if (r_count != {COUNT_BITS{1'b1}}) begin
                            count_step = r_count + COUNT_BITS'(1);
                        end
                        n_seen  = 1'b1;
                        n_count = count_step;
                        if (CMP_W'(count_step) >= need) begin
                            n_waiting = 1'b0;
                            n_seen    = 1'b0;
                            n_count   = '0;
                            n_pending = REQ_NONE;
                            n_armed   = 1'b1;
                        end
                    end else begin
                        n_seen  = 1'b0;
                        n_count = '0;
                    end
                end
            end
            OP_CONSUME: begin
                code      = r_pending;
                n_pending = REQ_NONE;
            end
            OP_REARM: begin
                n_pending = REQ_NONE;
                n_waiting = 1'b1;
                n_seen    = 1'b0;
                n_count   = '0;
            end
            default: begin
                code = REQ_NONE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed   <= 1'b1;
            r_waiting <= 1'b0;
            r_pending <= REQ_NONE;
            r_prev    <= 3'b000;
            r_seen    <= 1'b0;
            r_count   <= '0;
        end else if (i_accept) begin
            r_armed   <= n_armed;
            r_waiting <= n_waiting;
            r_pending <= n_pending;
            r_prev    <= n_prev;
            r_seen    <= n_seen;
            r_count   <= n_count;
        end
    end

    always_comb begin
        o_result.request_code     = code;
        o_result.wake             = wake;
        o_result.armed_now        = n_armed;
        o_result.awaiting_release = n_waiting;
    end

endmodule

`default_nettype wire

/* rtl/srlrd_out.sv */
// two-entry result register with skid stage toward the receiver
`default_nettype none

module srlrd_out
    import srlrd_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_push,
    input  wire t_out_item i_result,
    input  wire logic      i_out_stall,
    output logic           o_full,
    output logic           o_out_valid,
    output t_out_item      o_out_item
);

    logic [1:0] r_count;
    logic [1:0] n_count;
    t_out_item  r_head;
    t_out_item  r_skid;
    logic       pop;

    assign pop = (r_count != 2'd0) && !i_out_stall;

    always_comb begin
        n_count = r_count;
        if (i_push && !pop) begin
            n_count = r_count + 2'd1;
        end else if (!i_push && pop) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop && (r_count == 2'd2)) begin
            r_head <= r_skid;
        end else if (i_push && ((r_count == 2'd0) || pop)) begin
            r_head <= i_result;
        end
        if (i_push && (r_count == 2'd1) && !pop) begin
            r_skid <= i_result;
        end
    end

    assign o_full      = (r_count == 2'd2);
    assign o_out_valid = (r_count != 2'd0);
    assign o_out_item  = r_head;

endmodule

`default_nettype wire

/* rtl/shift_request_latch_release_debounce_unit.sv */
// shift request latch with release debounce: top level
//
// input channel: i_in_valid / o_in_stall carry one item per transfer, either a
// tick with the up, down and neutral switch levels, a consume, a clear and
// rearm, or the unused op code 3, which changes no state. output channel:
// o_out_valid / i_out_stall carry exactly one result per input transfer, in
// order. each result is written to the result buffer at its input transfer.
// throughput: one item per cycle while o_in_stall is low; all state updates
// are computed combinationally from the state registers. a two-entry result
// buffer lets inputs keep flowing while a result waits; o_in_stall rises only
// when both entries hold results the receiver has not taken.
// the apb port holds the release debounce tick count at address 0 (reset 20);
// the user writes it only while the block is idle; the block does not enforce it.
// after reset the block is armed, nothing is pending, all switches are taken
// as released and the result buffer is empty.
`default_nettype none

`include "shift_request_latch_release_debounce_unit_macros.svh"

module shift_request_latch_release_debounce_unit
    import srlrd_pkg::*;
#(
    parameter int unsigned COUNT_BITS = COUNT_BITS_DEF
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_item                  o_out_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    output logic      [APB_DATA_W-1:0] prdata,
    output logic                       pready
);

    logic                  in_xfer;
    logic                  full;
    logic [DEBOUNCE_W-1:0] release_ticks;
    t_out_item             result;

    assign o_in_stall = full;
    assign in_xfer    = i_in_valid && !full;

    srlrd_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_release_ticks (release_ticks)
    );

    srlrd_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (in_xfer),
        .i_item          (i_in_item),
        .i_release_ticks (release_ticks),
        .o_result        (result)
    );

    srlrd_out u_out (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (in_xfer),
        .i_result    (result),
        .i_out_stall (i_out_stall),
        .o_full      (full),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    `SRLRD_ASSERT_NOW(a_stall_means_results_held, i_clk, i_rst_n, o_in_stall, o_out_valid)
    `SRLRD_ASSERT_NOW(a_wake_leaves_disarmed, i_clk, i_rst_n, o_out_valid && o_out_item.wake, !o_out_item.armed_now)
    `SRLRD_ASSERT_NEXT(a_transfer_gives_result, i_clk, i_rst_n, in_xfer, o_out_valid)

endmodule

`default_nettype wire

/* tb/srlrd_status_checker.sv */
// checker for the shift request latch unit: predicts each result and compares it with the block
`timescale 1ns / 1ps

module srlrd_status_checker
    import srlrd_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    input  wire logic                  i_in_stall,
    input  wire t_in_item              i_in_item,
    input  wire logic                  i_out_valid,
    input  wire logic                  i_out_stall,
    input  wire t_out_item             i_out_item,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [APB_ADDR_W-1:0] paddr,
    input  wire logic [APB_DATA_W-1:0] pwdata,
    input  wire logic                  pready,
    output int                         o_mismatches,
    output int                         o_outstanding
);

    logic [DEBOUNCE_W-1:0]     release_ticks;
    logic                      armed;
    logic                      waiting;
    logic                      low_seen;
    logic [1:0]                pending;
    logic [2:0]                last_levels;
    logic [COUNT_BITS_DEF-1:0] low_count;
    t_out_item                 status_q[$];
    int                        errors;

    function automatic t_out_item advance_latch(t_in_item it);
        t_out_item   r;
        logic [2:0]  lv;
        logic [2:0]  rising;
        int unsigned need;
        r = '0;
        case (it.op)
            OP_TICK: begin
                lv = {it.neutral_level, it.down_level, it.up_level};
                rising = lv & ~last_levels;
                last_levels = lv;
                if (armed && pending == REQ_NONE && rising != 3'b000) begin
                    if (rising[0]) begin
                        pending = REQ_UP;
                    end else if (rising[1]) begin
                        pending = REQ_DOWN;
                    end else begin
                        pending = REQ_NEUTRAL;
                    end
                    armed = 1'b0;
                    r.wake = 1'b1;
                end
                if (waiting) begin
                    if (lv == 3'b000) begin
                        need = (release_ticks == '0) ? 1 : int'(release_ticks);
                        if (!low_seen) begin
                            low_seen = 1'b1;
                            low_count = '0;
                        end else if (low_count != '1) begin
                            low_count = low_count + 1'b1;
                        end
                        if (int'(low_count) >= need) begin
                            waiting = 1'b0;
                            low_seen = 1'b0;
                            low_count = '0;
                            pending = REQ_NONE;
                            armed = 1'b1;
                        end
                    end else begin
                        low_seen = 1'b0;
                        low_count = '0;
                    end
                end
            end
            OP_CONSUME: begin
                r.request_code = pending;
                pending = REQ_NONE;
            end
            OP_REARM: begin
                pending = REQ_NONE;
                waiting = 1'b1;
                low_seen = 1'b0;
                low_count = '0;
            end
            default: begin
            end
        endcase
        r.armed_now = armed;
        r.awaiting_release = waiting;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out_item want;
        if (!i_rst_n) begin
            release_ticks = DEBOUNCE_RESET;
            armed = 1'b1;
            waiting = 1'b0;
            low_seen = 1'b0;
            pending = REQ_NONE;
            last_levels = 3'b000;
            low_count = '0;
            status_q.delete();
            errors = 0;
        end else begin
            if (psel && penable && pwrite && pready && paddr == ADDR_RELEASE_TICKS) begin
                release_ticks = pwdata[DEBOUNCE_W-1:0];
            end
            if (i_out_valid && !i_out_stall) begin
                if (status_q.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("unexpected result: code %0d wake %0d armed %0d waiting %0d",
                                 i_out_item.request_code, i_out_item.wake,
                                 i_out_item.armed_now, i_out_item.awaiting_release);
                    end
                end else begin
                    want = status_q.pop_front();
                    if (i_out_item.request_code !== want.request_code ||
                        i_out_item.wake !== want.wake ||
                        i_out_item.armed_now !== want.armed_now ||
                        i_out_item.awaiting_release !== want.awaiting_release) begin
                        errors++;
                        if (errors <= 10) begin
                            $write("result mismatch: expected code %0d wake %0d armed %0d waiting %0d, ",
                                   want.request_code, want.wake, want.armed_now,
                                   want.awaiting_release);
                            $display("got code %0d wake %0d armed %0d waiting %0d",
                                     i_out_item.request_code, i_out_item.wake,
                                     i_out_item.armed_now, i_out_item.awaiting_release);
                        end
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                status_q.push_back(advance_latch(i_in_item));
            end
        end
        o_mismatches <= errors;
        o_outstanding <= status_q.size();
    end

endmodule

/* tb/tb_shift_request_latch_release_debounce_unit.sv */
// stimulus and verdict for the shift request latch with release debounce
`timescale 1ns / 1ps

module tb_shift_request_latch_release_debounce_unit;
    import srlrd_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int unsigned CYCLE_LIMIT = 400000;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    t_in_item              i_in_item   = '0;
    logic                  i_out_stall = 1'b0;
    logic                  psel        = 1'b0;
    logic                  penable     = 1'b0;
    logic                  pwrite      = 1'b0;
    logic [APB_ADDR_W-1:0] paddr       = '0;
    logic [APB_DATA_W-1:0] pwdata      = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_item             o_out_item;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int          mismatches;
    int          outstanding;
    logic        idle_en     = 1'b1;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;
    int unsigned items_sent  = 0;

    always #5 i_clk = ~i_clk;

    shift_request_latch_release_debounce_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_item  (o_out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    srlrd_status_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .i_in_stall    (o_in_stall),
        .i_in_item     (i_in_item),
        .i_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .i_out_item    (o_out_item),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .pready        (pready),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always @(posedge i_clk) begin
        if (!idle_en) begin
            i_out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 5) == 0) begin
            i_out_stall <= 1'b1;
            stall_left <= $urandom_range(1, 14) - 1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    function automatic t_in_item tick_item(logic [2:0] lv);
        t_in_item it;
        it.op = OP_TICK;
        it.up_level = lv[0];
        it.down_level = lv[1];
        it.neutral_level = lv[2];
        return it;
    endfunction

    // switch levels are ignored off a tick, so they carry noise
    function automatic t_in_item ctrl_item(logic [1:0] op);
        t_in_item it;
        it.op = op;
        {it.up_level, it.down_level, it.neutral_level} = 3'($urandom_range(0, 7));
        return it;
    endfunction

    task automatic push_item(input t_in_item it);
        int unsigned gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 14);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        items_sent++;
    endtask

    task automatic release_run(input int unsigned n);
        repeat (n) push_item(tick_item(3'b000));
    endtask

    task automatic drain;
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic set_release_ticks(input int unsigned value);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= ADDR_RELEASE_TICKS;
        pwdata <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic random_segment(input int unsigned ticks);
        int unsigned need;
        int unsigned run;
        int unsigned k;
        logic [2:0]  lv;
        need = (ticks == 0) ? 1 : ticks;
        run = (need + 1 > 40) ? 40 : need + 1;
        case ($urandom_range(0, 11))
            0, 1: begin
                lv = 3'($urandom_range(1, 7));
                push_item(tick_item(lv));
                k = $urandom_range(0, 2);
                repeat (k) push_item(tick_item(lv));
            end
            2: push_item(ctrl_item(OP_CONSUME));
            3: push_item(ctrl_item(OP_REARM));
            4, 5: begin
                push_item(ctrl_item(OP_REARM));
                release_run(run);
            end
            6: release_run($urandom_range(1, run));
            7: begin
                // release wait broken by a bounce
                release_run($urandom_range(1, run));
                push_item(tick_item(3'($urandom_range(1, 7))));
                release_run(run);
            end
            8: push_item(tick_item(3'($urandom_range(0, 7))));
            9: begin
                if ($urandom_range(0, 2) == 0) begin
                    push_item(ctrl_item(OP_UNUSED));
                end else begin
                    push_item(ctrl_item(OP_CONSUME));
                end
            end
            default: begin
                push_item(tick_item(3'b000));
                push_item(tick_item(3'($urandom_range(1, 7))));
                push_item(ctrl_item(OP_CONSUME));
                push_item(ctrl_item(OP_REARM));
                release_run(run);
            end
        endcase
    endtask

    task automatic run_phase(input int unsigned ticks, input int unsigned n);
        int unsigned target;
        set_release_ticks(ticks);
        target = items_sent + n;
        while (items_sent < target) random_segment(ticks);
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // all three rise together, up wins; later edges while disarmed are lost
        push_item(tick_item(3'b000));
        push_item(tick_item(3'b111));
        push_item(tick_item(3'b000));
        push_item(tick_item(3'b010));
        push_item(ctrl_item(OP_CONSUME));
        push_item(ctrl_item(OP_CONSUME));
        push_item(ctrl_item(OP_UNUSED));
        push_item(ctrl_item(OP_REARM));
        release_run(3);

        set_release_ticks(1);
        push_item(tick_item(3'b000));
        push_item(tick_item(3'b110));
        push_item(ctrl_item(OP_CONSUME));
        push_item(ctrl_item(OP_REARM));
        release_run(2);
        // rearm while armed, then an edge during the wait
        push_item(ctrl_item(OP_REARM));
        push_item(tick_item(3'b100));
        push_item(tick_item(3'b000));
        // repeated rearm restarts the wait
        push_item(ctrl_item(OP_REARM));
        release_run(2);
        push_item(ctrl_item(OP_CONSUME));
        push_item(tick_item(3'b100));
        push_item(ctrl_item(OP_CONSUME));

        // zero debounce behaves as one
        set_release_ticks(0);
        push_item(ctrl_item(OP_REARM));
        release_run(2);
        push_item(tick_item(3'b001));
        push_item(ctrl_item(OP_CONSUME));

        run_phase(20, 220);
        run_phase(1, 250);
        run_phase(3, 250);
        run_phase(65535, 120);
        run_phase(0, 150);
        run_phase($urandom_range(2, 8), 250);
        idle_en <= 1'b0;
        run_phase(2, 200);

        drain();
        if (mismatches == 0 && outstanding == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/srlrd_pkg.sv
rtl/srlrd_cfg.sv
rtl/srlrd_core.sv
rtl/srlrd_out.sv
rtl/shift_request_latch_release_debounce_unit.sv
tb/srlrd_status_checker.sv
tb/tb_shift_request_latch_release_debounce_unit.sv
